// File: src/afd_pkg.sv
package afd_pkg;

   // frame geometry
   localparam int PAYLOAD_BYTES   = 8;
   localparam int FRAME_BYTES_MAX = 24;
   localparam int PAYLOAD_BITS    = 8 * PAYLOAD_BYTES;
   localparam int ADDR_BYTES      = 8;
   localparam int POS_BITS        = 5;

   // link and frame type codes
   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] ESC_XOR    = 8'h20;
   localparam logic [7:0] TYPE_RX    = 8'h90;
   localparam logic [7:0] TYPE_MODEM = 8'h8A;
   localparam logic [7:0] SUM_BASE   = 8'hFF;

   // decoded byte positions inside a frame
   localparam logic [POS_BITS-1:0] POS_IDLE    = 5'd0;
   localparam logic [POS_BITS-1:0] POS_LEN_HI  = 5'd1;
   localparam logic [POS_BITS-1:0] POS_LEN_LO  = 5'd2;
   localparam logic [POS_BITS-1:0] POS_TYPE    = 5'd3;
   localparam logic [POS_BITS-1:0] POS_ADDR    = 5'd4;
   localparam logic [POS_BITS-1:0] POS_MODEM   = 5'd4;
   localparam logic [POS_BITS-1:0] POS_SRC_HI  = 5'd12;
   localparam logic [POS_BITS-1:0] POS_SRC_LO  = 5'd13;
   localparam logic [POS_BITS-1:0] POS_OPT     = 5'd14;
   localparam logic [POS_BITS-1:0] POS_PAYLOAD = 5'd15;

   // bytes around the length field: delimiter, two length bytes, checksum
   localparam logic [16:0] FRAME_OVERHEAD = 17'd4;
   localparam logic [15:0] CSUM_OFFSET    = 16'd3;

   // result status codes
   localparam logic [2:0] ST_RX_OK     = 3'd0;
   localparam logic [2:0] ST_MODEM_OK  = 3'd1;
   localparam logic [2:0] ST_CSUM_ERR  = 3'd2;
   localparam logic [2:0] ST_UNHANDLED = 3'd3;
   localparam logic [2:0] ST_LEN_ERR   = 3'd4;

   typedef struct packed {
      logic [2:0]  frame_status;
      logic [7:0]  frame_type;
      logic [63:0] dest_address;
      logic [15:0] source_address;
      logic [7:0]  receive_options;
      logic [63:0] payload;
      logic [7:0]  device_status;
   } result_type;

endpackage

// File: src/afd_req_if.sv
interface afd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] raw_byte;
   logic       frame_start;

   modport source (output valid, output raw_byte, output frame_start, input ready);
   modport sink   (input valid, input raw_byte, input frame_start, output ready);
endinterface

// File: src/afd_rsp_if.sv
interface afd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  frame_status;
   logic [7:0]  frame_type;
   logic [63:0] dest_address;
   logic [15:0] source_address;
   logic [7:0]  receive_options;
   logic [63:0] payload;
   logic [7:0]  device_status;

   modport source (
      output valid, output frame_status, output frame_type, output dest_address,
      output source_address, output receive_options, output payload,
      output device_status, input ready
   );
   modport sink (
      input valid, input frame_status, input frame_type, input dest_address,
      input source_address, input receive_options, input payload,
      input device_status, output ready
   );
endinterface

// File: src/afd_in_stage.sv
module afd_in_stage (
   input  logic       clock,
   input  logic       reset,
   afd_req_if.sink    req_chan,
   input  logic       take,
   output logic       byte_valid,
   output logic [7:0] raw_byte,
   output logic       frame_start
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       start_ff;
   logic       load;

   // register refills in the same cycle the held byte is consumed
   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= req_chan.raw_byte;
         start_ff <= req_chan.frame_start;
      end
   end

   assign byte_valid  = valid_ff;
   assign raw_byte    = byte_ff;
   assign frame_start = start_ff;

endmodule

// File: src/afd_parser.sv
module afd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         raw_byte,
   input  logic               frame_start,
   output logic               res_valid,
   output afd_pkg::result_type result
);

   logic [afd_pkg::POS_BITS-1:0]     index_ff, index_in;
   logic                             esc_ff, esc_in;
   logic                             skip_ff, skip_in;
   logic [7:0]                       sum_ff, sum_in;
   logic [15:0]                      len_ff, len_in;
   logic [7:0]                       type_ff, type_in;
   logic [63:0]                      addr_ff, addr_in;
   logic [15:0]                      src_ff, src_in;
   logic [7:0]                       opt_ff, opt_in;
   logic [afd_pkg::PAYLOAD_BITS-1:0] pay_ff, pay_in;

   logic [7:0]  b;
   logic [7:0]  expect_sum;
   logic [15:0] len_full;
   logic        active;

   assign b          = esc_ff ? (raw_byte ^ afd_pkg::ESC_XOR) : raw_byte;
   assign expect_sum = afd_pkg::SUM_BASE - sum_ff;
   assign len_full   = {len_ff[15:8], b};
   assign active     = !skip_ff && (index_ff != afd_pkg::POS_IDLE);

   always_comb begin
      index_in  = index_ff;
      esc_in    = esc_ff;
      skip_in   = skip_ff;
      sum_in    = sum_ff;
      len_in    = len_ff;
      type_in   = type_ff;
      addr_in   = addr_ff;
      src_in    = src_ff;
      opt_in    = opt_ff;
      pay_in    = pay_ff;
      res_valid = 1'b0;
      result    = '0;

      priority if (frame_start) begin
         index_in = afd_pkg::POS_LEN_HI;
         esc_in   = 1'b0;
         skip_in  = 1'b0;
         sum_in   = '0;
         len_in   = '0;
         type_in  = '0;
         addr_in  = '0;
         src_in   = '0;
         opt_in   = '0;
         pay_in   = '0;
      end else if (!active) begin
         // idle or skipping: byte dropped
      end else if (!esc_ff && (raw_byte == afd_pkg::ESC_BYTE)) begin
         esc_in = 1'b1;
      end else begin
         esc_in = 1'b0;
         priority if (index_ff == afd_pkg::POS_LEN_HI) begin
            len_in   = {b, 8'h00};
            index_in = afd_pkg::POS_LEN_LO;
         end else if (index_ff == afd_pkg::POS_LEN_LO) begin
            len_in = len_full;
            if ((len_full == 16'd0) ||
                (({1'b0, len_full} + afd_pkg::FRAME_OVERHEAD) >
                 17'(afd_pkg::FRAME_BYTES_MAX))) begin
               res_valid           = 1'b1;
               result.frame_status = afd_pkg::ST_LEN_ERR;
               skip_in             = 1'b1;
               index_in            = afd_pkg::POS_IDLE;
            end else begin
               index_in = afd_pkg::POS_TYPE;
            end
         end else if (index_ff == afd_pkg::POS_TYPE) begin
            type_in = b;
            sum_in  = b;
            if ((b != afd_pkg::TYPE_RX) && (b != afd_pkg::TYPE_MODEM)) begin
               res_valid           = 1'b1;
               result.frame_status = afd_pkg::ST_UNHANDLED;
               result.frame_type   = b;
               skip_in             = 1'b1;
               index_in            = afd_pkg::POS_IDLE;
            end else begin
               index_in = afd_pkg::POS_ADDR;
            end
         end else if ({12'd0, index_ff} == ({1'b0, len_ff} + {1'b0, afd_pkg::CSUM_OFFSET})) begin
            // checksum byte closes the frame
            res_valid         = 1'b1;
            result.frame_type = type_ff;
            priority if (expect_sum != b) begin
               result.frame_status = afd_pkg::ST_CSUM_ERR;
            end else if (type_ff == afd_pkg::TYPE_RX) begin
               result.frame_status    = afd_pkg::ST_RX_OK;
               result.dest_address    = addr_ff;
               result.source_address  = src_ff;
               result.receive_options = opt_ff;
               result.payload         = 64'(pay_ff);
            end else begin
               result.frame_status  = afd_pkg::ST_MODEM_OK;
               result.device_status = opt_ff;
            end
            index_in = afd_pkg::POS_IDLE;
         end else begin
            sum_in   = sum_ff + b;
            index_in = index_ff + 5'd1;
            if (type_ff == afd_pkg::TYPE_RX) begin
               for (int k = 0; k < afd_pkg::ADDR_BYTES; k++) begin
                  if (index_ff == (afd_pkg::POS_ADDR + 5'(k))) begin
                     addr_in[8*(afd_pkg::ADDR_BYTES-1-k) +: 8] = b;
                  end
               end
               if (index_ff == afd_pkg::POS_SRC_HI) begin
                  src_in[15:8] = b;
               end
               if (index_ff == afd_pkg::POS_SRC_LO) begin
                  src_in[7:0] = b;
               end
               if (index_ff == afd_pkg::POS_OPT) begin
                  opt_in = b;
               end
               for (int k = 0; k < afd_pkg::PAYLOAD_BYTES; k++) begin
                  if (index_ff == (afd_pkg::POS_PAYLOAD + 5'(k))) begin
                     pay_in[8*(afd_pkg::PAYLOAD_BYTES-1-k) +: 8] = b;
                  end
               end
            end else if (index_ff == afd_pkg::POS_MODEM) begin
               opt_in = b;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= afd_pkg::POS_IDLE;
         esc_ff   <= 1'b0;
         skip_ff  <= 1'b0;
      end else if (step) begin
         index_ff <= index_in;
         esc_ff   <= esc_in;
         skip_ff  <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         sum_ff  <= sum_in;
         len_ff  <= len_in;
         type_ff <= type_in;
         addr_ff <= addr_in;
         src_ff  <= src_in;
         opt_ff  <= opt_in;
         pay_ff  <= pay_in;
      end
   end

endmodule

// File: src/afd_out_stage.sv
module afd_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  afd_pkg::result_type result,
   output logic               free,
   afd_rsp_if.source          rsp_chan
);

   logic                valid_ff;
   logic                valid_in;
   afd_pkg::result_type data_ff;

   assign free     = !valid_ff || rsp_chan.ready;
   assign valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.frame_status    = data_ff.frame_status;
   assign rsp_chan.frame_type      = data_ff.frame_type;
   assign rsp_chan.dest_address    = data_ff.dest_address;
   assign rsp_chan.source_address  = data_ff.source_address;
   assign rsp_chan.receive_options = data_ff.receive_options;
   assign rsp_chan.payload         = data_ff.payload;
   assign rsp_chan.device_status   = data_ff.device_status;

endmodule

// File: src/api_frame_deframer.sv
// escaped api frame deframer: takes one raw link byte per req transaction, with
// frame_start marking the delimiter, undoes 0x7d escapes (next byte xor 0x20),
// tracks the big-endian length and the running sum from the type byte on, and
// issues one rsp transaction per frame: receive ok with address, source, options
// and payload fields; modem status ok with the status byte; checksum error; or,
// reported early and with the rest of the frame skipped, an unhandled type or a
// length error (zero length or a frame longer than the buffer). a new frame_start
// drops any frame in progress without a report. one byte is taken every cycle
// while the pipeline is not held; a result is offered on rsp once its closing
// byte has been decoded out of the input register and loaded into the result
// register. a stalled rsp side holds the pipeline only when a byte that yields
// a result meets a full result register.
module api_frame_deframer (
   input  logic      clock,
   input  logic      reset,
   afd_req_if.sink   req_chan,
   afd_rsp_if.source rsp_chan
);

   // held input byte
   logic       byte_valid;
   logic [7:0] held_byte;
   logic       held_start;

   // decode outputs
   logic                res_valid;
   afd_pkg::result_type result;

   // pipeline control
   logic out_free;
   logic fire;

   // a byte moves on unless it makes a result and the result register is busy
   assign fire = byte_valid && (!res_valid || out_free);

   afd_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .take        (fire),
      .byte_valid  (byte_valid),
      .raw_byte    (held_byte),
      .frame_start (held_start)
   );

   // unescape, field capture and checksum against the frame state
   afd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (fire),
      .raw_byte    (held_byte),
      .frame_start (held_start),
      .res_valid   (res_valid),
      .result      (result)
   );

   // result register facing the rsp channel
   afd_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (fire && res_valid),
      .result   (result),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: tb/api_frame_deframer_tb.sv
module api_frame_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // run limits
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int PRINT_LIMIT   = 40;
   localparam int BYTES_MIXED   = 850;
   localparam int BYTES_TOTAL   = 1350;
   localparam int BODY_MAX      = afd_pkg::FRAME_BYTES_MAX - 4;

   // usual delimiter value on the link
   localparam logic [7:0] FRAME_DELIM = 8'h7E;

   logic clock = 1'b0;
   logic reset;

   afd_req_if req_if ();
   afd_rsp_if rsp_if ();

   api_frame_deframer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // frame decoder model: own copy of the parser state
   // ------------------------------------------------------------------
   logic [4:0]  pos_next;    // next decoded position, idle when zero
   bit          esc_seen;    // last raw byte was an escape
   logic [7:0]  sum_run;     // running sum from the type byte on
   logic [15:0] len_field;
   logic [7:0]  type_seen;
   logic [63:0] addr_acc;
   logic [15:0] src_acc;
   logic [7:0]  opt_acc;     // receive options, or the modem status byte
   logic [63:0] data_acc;
   bit          skip_rest;   // rest of the frame is ignored

   afd_pkg::result_type pending_frames[$];   // frame reports still to come out
   int         bytes_taken;         // bytes accepted on the req side
   int         mismatch_count;
   int         cycle_count;

   // traffic shaping shared with the rsp side
   bit         req_idle_en;
   bit         rsp_idle_en;
   int         hold_request;
   int         rsp_wait;

   function automatic void clear_frame_state();
      pos_next  = afd_pkg::POS_IDLE;
      esc_seen  = 1'b0;
      sum_run   = '0;
      len_field = '0;
      type_seen = '0;
      addr_acc  = '0;
      src_acc   = '0;
      opt_acc   = '0;
      data_acc  = '0;
      skip_rest = 1'b0;
   endfunction

   // returns 1 when this byte closes a report, with the report in frame_rpt
   function automatic bit decode_byte(input logic [7:0] raw, input bit is_start,
                                      output afd_pkg::result_type frame_rpt);
      logic [7:0] b;
      logic [4:0] pos;
      frame_rpt = '0;
      // delimiter: always opens a fresh frame, never an escape
      if (is_start) begin
         clear_frame_state();
         pos_next = afd_pkg::POS_LEN_HI;
         return 1'b0;
      end
      // idle line or a frame being skipped
      if (skip_rest || pos_next == afd_pkg::POS_IDLE)
         return 1'b0;
      if (esc_seen) begin
         b = raw ^ afd_pkg::ESC_XOR;
         esc_seen = 1'b0;
      end else if (raw == afd_pkg::ESC_BYTE) begin
         esc_seen = 1'b1;
         return 1'b0;
      end else begin
         b = raw;
      end
      pos = pos_next;
      if (pos == afd_pkg::POS_LEN_HI) begin
         len_field = {b, 8'h00};
         pos_next = afd_pkg::POS_LEN_LO;
         return 1'b0;
      end
      if (pos == afd_pkg::POS_LEN_LO) begin
         len_field = {len_field[15:8], b};
         // zero length or a frame that does not fit the buffer
         if (len_field == 16'd0 ||
             ({1'b0, len_field} + afd_pkg::FRAME_OVERHEAD) >
             17'(afd_pkg::FRAME_BYTES_MAX)) begin
            frame_rpt.frame_status = afd_pkg::ST_LEN_ERR;
            skip_rest = 1'b1;
            pos_next = afd_pkg::POS_IDLE;
            return 1'b1;
         end
         pos_next = afd_pkg::POS_TYPE;
         return 1'b0;
      end
      if (pos == afd_pkg::POS_TYPE) begin
         type_seen = b;
         sum_run = b;
         // unknown type is reported right away, rest of frame dropped
         if (b != afd_pkg::TYPE_RX && b != afd_pkg::TYPE_MODEM) begin
            frame_rpt.frame_status = afd_pkg::ST_UNHANDLED;
            frame_rpt.frame_type = b;
            skip_rest = 1'b1;
            pos_next = afd_pkg::POS_IDLE;
            return 1'b1;
         end
         pos_next = afd_pkg::POS_ADDR;
         return 1'b0;
      end
      // checksum position closes the frame
      if (16'(pos) == len_field + afd_pkg::CSUM_OFFSET) begin
         frame_rpt.frame_type = type_seen;
         if (b != afd_pkg::SUM_BASE - sum_run) begin
            frame_rpt.frame_status = afd_pkg::ST_CSUM_ERR;
         end else if (type_seen == afd_pkg::TYPE_RX) begin
            frame_rpt.frame_status    = afd_pkg::ST_RX_OK;
            frame_rpt.dest_address    = addr_acc;
            frame_rpt.source_address  = src_acc;
            frame_rpt.receive_options = opt_acc;
            frame_rpt.payload         = data_acc;
         end else begin
            frame_rpt.frame_status  = afd_pkg::ST_MODEM_OK;
            frame_rpt.device_status = opt_acc;
         end
         pos_next = afd_pkg::POS_IDLE;
         esc_seen = 1'b0;
         return 1'b1;
      end
      sum_run = sum_run + b;
      if (type_seen == afd_pkg::TYPE_RX) begin
         if (pos >= afd_pkg::POS_ADDR && pos < afd_pkg::POS_SRC_HI)
            addr_acc |= 64'(b) << (8 * (int'(afd_pkg::POS_SRC_HI) - 1 - int'(pos)));
         else if (pos == afd_pkg::POS_SRC_HI)
            src_acc[15:8] = b;
         else if (pos == afd_pkg::POS_SRC_LO)
            src_acc[7:0] = b;
         else if (pos == afd_pkg::POS_OPT)
            opt_acc = b;
         else if (int'(pos) < int'(afd_pkg::POS_PAYLOAD) + afd_pkg::PAYLOAD_BYTES)
            // first payload byte lands in the top byte
            data_acc |= 64'(b) <<
               (8 * (afd_pkg::PAYLOAD_BYTES - 1 -
                     (int'(pos) - int'(afd_pkg::POS_PAYLOAD))));
      end else if (pos == afd_pkg::POS_MODEM) begin
         opt_acc = b;
      end
      pos_next = pos + 5'd1;
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // mismatch reporting
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch(name, got, want);
   endtask

   // ------------------------------------------------------------------
   // req side: one byte per transaction, driven at the falling edge
   // ------------------------------------------------------------------
   // entered at a rising edge (or before the first falling edge); returns at
   // the rising edge where the transaction was accepted
   task automatic send_byte(input logic [7:0] raw, input bit is_start);
      int gap;
      afd_pkg::result_type frame_rpt;
      @(negedge clock);
      if (req_idle_en && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.raw_byte    <= raw;
      req_if.frame_start <= is_start;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      bytes_taken++;
      if (decode_byte(raw, is_start, frame_rpt))
         pending_frames.push_back(frame_rpt);
   endtask

   // first byte goes out as the delimiter, the rest as plain link bytes
   task automatic send_sequence(input logic [7:0] seq_bytes[$]);
      foreach (seq_bytes[i])
         send_byte(seq_bytes[i], i == 0);
   endtask

   // drop valid and wait until every pending report has come out
   task automatic wait_for_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_frames.size() != 0)
         @(posedge clock);
   endtask

   // one frame with random content, mostly well formed
   task automatic send_random_frame();
      logic [7:0] body[$];
      logic [7:0] ftype;
      logic [7:0] d;
      logic [7:0] sum;
      logic [15:0] flen;
      int kind;
      int body_len;
      int cut;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
         ftype = afd_pkg::TYPE_RX;
      end else if (kind < 80) begin
         ftype = afd_pkg::TYPE_MODEM;
      end else begin
         do ftype = 8'($urandom);
         while (ftype == afd_pkg::TYPE_RX || ftype == afd_pkg::TYPE_MODEM);
      end
      if (kind >= 94)
         // length out of range: zero or too long for the buffer
         flen = $urandom_range(0, 1) ? 16'd0
                                     : 16'($urandom_range(BODY_MAX + 1, 16'hFFFF));
      else if ($urandom_range(0, 3) == 0)
         flen = 16'(BODY_MAX);
      else
         flen = 16'($urandom_range(1, BODY_MAX));
      body_len = (flen > BODY_MAX) ? BODY_MAX : int'(flen);
      body.push_back(flen[15:8]);
      body.push_back(flen[7:0]);
      body.push_back(ftype);
      sum = ftype;
      for (int i = 1; i < body_len; i++) begin
         // lean on the bytes that matter to the escape logic
         case ($urandom_range(0, 11))
            0: d = afd_pkg::ESC_BYTE;
            1: d = FRAME_DELIM;
            2: d = afd_pkg::ESC_BYTE ^ afd_pkg::ESC_XOR;
            3: d = afd_pkg::ESC_XOR;
            default: d = 8'($urandom);
         endcase
         body.push_back(d);
         sum = sum + d;
      end
      d = afd_pkg::SUM_BASE - sum;
      if ($urandom_range(0, 7) == 0)
         d = d ^ 8'($urandom_range(1, 255));   // corrupt checksum
      body.push_back(d);

      // occasionally cut the frame short so the next delimiter restarts
      cut = body.size();
      if ($urandom_range(0, 15) == 0)
         cut = $urandom_range(0, body.size() - 1);

      send_byte($urandom_range(0, 7) == 0 ? 8'($urandom) : FRAME_DELIM, 1'b1);
      for (int i = 0; i < cut; i++) begin
         if ($urandom_range(0, 49) == 0) begin
            // stray escape: the next byte gets flipped, frame goes wrong
            send_byte(afd_pkg::ESC_BYTE, 1'b0);
            send_byte(body[i], 1'b0);
         end else if (body[i] == afd_pkg::ESC_BYTE || $urandom_range(0, 9) == 0) begin
            send_byte(afd_pkg::ESC_BYTE, 1'b0);
            send_byte(body[i] ^ afd_pkg::ESC_XOR, 1'b0);
         end else begin
            send_byte(body[i], 1'b0);
         end
      end
      // line noise between frames, ignored by the parser
      if (cut == body.size() && $urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
   endtask

   // ------------------------------------------------------------------
   // rsp side: ready with random hold-off bursts and the long stall
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request > 0) begin
         rsp_wait = hold_request;
         hold_request = 0;
      end
      if (rsp_wait > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_wait--;
      end else if (rsp_idle_en && $urandom_range(0, 9) == 0) begin
         rsp_if.ready <= 1'b0;
         rsp_wait = $urandom_range(1, 15) - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // every rsp transaction is checked against the oldest pending report
   always @(posedge clock) begin : result_check
      afd_pkg::result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_frames.size() == 0) begin
            report_mismatch("report with nothing pending", 64'(rsp_if.frame_status), '0);
         end else begin
            want = pending_frames.pop_front();
            check_field("frame_status", 64'(rsp_if.frame_status), 64'(want.frame_status));
            check_field("frame_type", 64'(rsp_if.frame_type), 64'(want.frame_type));
            check_field("dest_address", rsp_if.dest_address, want.dest_address);
            check_field("source_address", 64'(rsp_if.source_address),
                        64'(want.source_address));
            check_field("receive_options", 64'(rsp_if.receive_options),
                        64'(want.receive_options));
            check_field("payload", rsp_if.payload, want.payload);
            check_field("device_status", 64'(rsp_if.device_status),
                        64'(want.device_status));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL api_frame_deframer");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // bytes before any delimiter are dropped
   task automatic test_idle_bytes();
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
   endtask

   // zero length and the largest length both report early
   task automatic test_length_errors();
      send_sequence({FRAME_DELIM, 8'h00, 8'h00});
      send_sequence({FRAME_DELIM, 8'hFF, 8'hFF});
   endtask

   // unknown type, with an escape value as the delimiter (taken as is)
   task automatic test_unhandled_type();
      send_sequence({afd_pkg::ESC_BYTE, 8'h00, 8'h01, 8'hFF, 8'h00});
   endtask

   // modem frame with length one: no status byte, reads as zero
   task automatic test_short_modem();
      send_sequence({FRAME_DELIM, 8'h00, 8'h01, afd_pkg::TYPE_MODEM,
                     afd_pkg::SUM_BASE - afd_pkg::TYPE_MODEM});
   endtask

   // delimiter mid frame drops it; escaped length and status byte after
   task automatic test_restart_escaped();
      send_sequence({FRAME_DELIM, 8'h00});
      send_sequence({FRAME_DELIM, afd_pkg::ESC_BYTE, afd_pkg::ESC_XOR, 8'h02,
                     afd_pkg::TYPE_MODEM, afd_pkg::ESC_BYTE,
                     afd_pkg::ESC_BYTE ^ afd_pkg::ESC_XOR,
                     afd_pkg::SUM_BASE - 8'(afd_pkg::TYPE_MODEM + afd_pkg::ESC_BYTE)});
   endtask

   // wrong checksum only reports the type
   task automatic test_bad_checksum();
      send_sequence({FRAME_DELIM, 8'h00, 8'h01, afd_pkg::TYPE_RX, 8'h00});
   endtask

   // random frames with idling on both sides, switched per stretch
   task automatic test_random_frames(input int byte_goal, input bit idle_on);
      int frames;
      frames = 0;
      while (bytes_taken < byte_goal) begin
         if (frames % 12 == 0) begin
            req_idle_en = idle_on && $urandom_range(0, 2) != 0;
            rsp_idle_en = idle_on && $urandom_range(0, 2) != 0;
         end
         send_random_frame();
         frames++;
      end
   endtask

   // rsp side holds off while short error frames keep coming, so the
   // result register fills and the req side must stall
   task automatic test_rsp_backpressure();
      req_idle_en = 1'b0;
      hold_request = HOLD_CYCLES;
      repeat (12) send_sequence({FRAME_DELIM, 8'h00, 8'h00});
      repeat (4) send_random_frame();
   endtask

   // sender stops until every report is out, then carries on
   task automatic test_sender_pause();
      repeat (3) send_random_frame();
      wait_for_results();
      repeat (3) send_random_frame();
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.raw_byte = '0;
      req_if.frame_start = 1'b0;
      rsp_if.ready = 1'b0;
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      hold_request = 0;
      rsp_wait = 0;
      bytes_taken = 0;
      mismatch_count = 0;
      cycle_count = 0;
      clear_frame_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_bytes();
      test_length_errors();
      test_unhandled_type();
      test_short_modem();
      test_restart_escaped();
      test_bad_checksum();
      test_random_frames(BYTES_MIXED, 1'b1);
      test_rsp_backpressure();
      test_sender_pause();
      // last stretch runs flat out
      test_random_frames(BYTES_TOTAL, 1'b0);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS api_frame_deframer");
      else
         $display("FAIL api_frame_deframer");
      $finish;
   end

endmodule

// File: api_frame_deframer.f
src/afd_pkg.sv
src/afd_req_if.sv
src/afd_rsp_if.sv
src/afd_in_stage.sv
src/afd_parser.sv
src/afd_out_stage.sv
src/api_frame_deframer.sv
tb/api_frame_deframer_tb.sv
